@@ hdl/sdz_pkg.sv @@
// Shared constants for the stick radial dead-zone pipeline.
// No dependencies; used by stick_radial_deadzone through scoped names.
`default_nettype none
package sdz_pkg;

	// Register indexes on the write port
	localparam logic REG_INNER = 1'b0;
	localparam logic REG_OUTER = 1'b1;

	// Reset values, Q0.16
	localparam logic [15:0] INNER_RESET = 16'd19661;
	localparam logic [15:0] OUTER_RESET = 16'd6554;

	// Formats
	localparam int AXW = 17;   // signed Q1.15 axis after inversion
	localparam int RW  = 17;   // radius in Q.16, up to about 1.414
	localparam int QW  = 16;   // quotient bits of both divisions

	// Full response, 1.0 in Q1.16
	localparam logic [16:0] T_FULL = 17'h10000;

endpackage
`default_nettype wire

@@ hdl/stick_radial_deadzone.sv @@
// Pipeline: 3 front stages, 17-stage root, 1 rim stage, 16-stage response divider,
//   3 multiply stages, 16-stage scaling divider, out reg.
// Throughput: one sample per cycle while s_tready is high; bit-per-stage pipelines set the depth.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (arst_n low, asynchronous): pipeline and output empty, rims back to 0.3 and 0.1.
// Depends on sdz_pkg, sdz_sqrt, sdz_div.
`default_nettype none
module stick_radial_deadzone #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] x_raw, [31:16] y_raw
	// conditioned vector stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [16:0] x_out, [33:17] y_out, [39:34] zero
	// register writes
	input  wire logic        wr_en,
	input  wire logic        wr_index,  // 0 inner dead-zone rim, 1 outer margin
	input  wire logic [15:0] wr_data
);

	localparam int AXW   = sdz_pkg::AXW;
	localparam int RW    = sdz_pkg::RW;
	localparam int QW    = sdz_pkg::QW;
	localparam int SHIFT = 16 - SAMPLE_BITS;

	// ---------------- configuration ----------------
	logic [15:0] inner_q, outer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= sdz_pkg::INNER_RESET;
			outer_q <= sdz_pkg::OUTER_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				sdz_pkg::REG_INNER: inner_q <= wr_data;
				sdz_pkg::REG_OUTER: outer_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline moves together; stalls only once the output buffer is full.
	logic ce;
	logic skid_vld_q;
	assign ce       = !skid_vld_q;
	assign s_tready = ce;

	// ---------------- S1: normalize, invert Y, magnitudes ----------------
	logic [15:0]           nx, ny;
	logic signed [AXW-1:0] sx_in, sy_in;
	assign nx    = s_tdata[15:0] << SHIFT;   // drops bits above SAMPLE_BITS-1
	assign ny    = s_tdata[31:16] << SHIFT;
	assign sx_in = {nx[15], nx};
	assign sy_in = -$signed({ny[15], ny});

	logic                  v_s1;
	logic signed [AXW-1:0] sx_s1, sy_s1;
	logic [AXW-1:0]        ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ce) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sx_s1 <= sx_in;
			sy_s1 <= sy_in;
			ax_s1 <= sx_in[AXW-1] ? AXW'(-sx_in) : AXW'(sx_in);
			ay_s1 <= sy_in[AXW-1] ? AXW'(-sy_in) : AXW'(sy_in);
		end
	end

	// ---------------- S2: squares ----------------
	logic [2*AXW-1:0] sqx, sqy;
	assign sqx = ax_s1 * ax_s1;
	assign sqy = ay_s1 * ay_s1;

	logic                  v_s2;
	logic signed [AXW-1:0] sx_s2, sy_s2;
	logic [30:0]           sqx_s2, sqy_s2;   // each at most 2^30

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ce) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			sqx_s2 <= sqx[30:0];
			sqy_s2 <= sqy[30:0];
		end
	end

	// ---------------- S3: r2 sum ----------------
	logic                  v_s3;
	logic signed [AXW-1:0] sx_s3, sy_s3;
	logic [31:0]           r2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (ce) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			r2_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	// ---------------- radius d16 = isqrt(4*r2) ----------------
	logic              v_rt;
	logic [RW-1:0]     d16_rt;
	logic [2*AXW-1:0]  pay_rt;

	sdz_sqrt #(.RW(RW), .PW(2*AXW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s3),
		.in_rad    ({r2_s3, 2'b00}),
		.in_pay    ({sy_s3, sx_s3}),
		.out_valid (v_rt),
		.out_root  (d16_rt),
		.out_pay   (pay_rt)
	);

	// ---------------- rim stage ----------------
	logic [RW-1:0]     num;
	logic signed [18:0] den;
	logic              den_pos, dz, sat;

	assign num     = d16_rt - {1'b0, inner_q};
	assign den     = 19'sd65536 - $signed({3'b0, inner_q}) - $signed({3'b0, outer_q});
	assign den_pos = !den[18] && (den != 19'sd0);
	assign dz      = (d16_rt < {1'b0, inner_q}) || (d16_rt == '0);
	assign sat     = !den_pos || ({2'b0, num} >= den[18:0]);

	logic                  v_s4;
	logic [2*AXW-1:0]      pay_s4;
	logic [RW-1:0]         d16_s4;
	logic [RW-1:0]         rem_s4, div_s4;
	logic                  dz_s4, sat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (ce) v_s4 <= v_rt;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			pay_s4 <= pay_rt;
			d16_s4 <= d16_rt;
			dz_s4  <= dz;
			sat_s4 <= sat;
			// keep the divider in range when its result is not used
			rem_s4 <= (dz || sat) ? '0 : num;
			div_s4 <= (dz || sat) ? RW'(1) : den[RW-1:0];
		end
	end

	// ---------------- t = (d16 - inner) * 65536 / den ----------------
	localparam int TPW = 2*AXW + RW + 2;
	logic           v_td;
	logic [QW-1:0]  q_td;
	logic [TPW-1:0] pay_td;

	sdz_div #(.DW(RW), .QW(QW), .PW(TPW)) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.in_rem    (rem_s4),
		.in_low    ('0),
		.in_div    (div_s4),
		.in_pay    ({sat_s4, dz_s4, d16_s4, pay_s4}),
		.out_valid (v_td),
		.out_quo   (q_td),
		.out_pay   (pay_td)
	);

	// ---------------- M1: t^2 ----------------
	logic [16:0] t;
	logic [33:0] tsq;
	assign t   = pay_td[TPW-1] ? sdz_pkg::T_FULL : {1'b0, q_td};
	assign tsq = t * t;

	logic                  v_s5;
	logic [32:0]           t2_s5;
	logic [RW-1:0]         d16_s5;
	logic                  dz_s5, nx_s5, ny_s5;
	logic [AXW-1:0]        ax_s5, ay_s5;
	logic signed [AXW-1:0] psx, psy;

	assign psx = pay_td[AXW-1:0];
	assign psy = pay_td[2*AXW-1:AXW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (ce) v_s5 <= v_td;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			t2_s5  <= tsq[32:0];
			d16_s5 <= pay_td[2*AXW +: RW];
			dz_s5  <= pay_td[TPW-2];
			nx_s5  <= psx[AXW-1];
			ny_s5  <= psy[AXW-1];
			ax_s5  <= psx[AXW-1] ? AXW'(-psx) : AXW'(psx);
			ay_s5  <= psy[AXW-1] ? AXW'(-psy) : AXW'(psy);
		end
	end

	// ---------------- M2: |s| * t2 split in two partial products ----------------
	logic [32:0] plx, ply;
	logic [33:0] phx, phy;
	assign plx = ax_s5 * t2_s5[15:0];
	assign ply = ay_s5 * t2_s5[15:0];
	assign phx = ax_s5 * t2_s5[32:16];
	assign phy = ay_s5 * t2_s5[32:16];

	logic          v_s6;
	logic [32:0]   plx_s6, ply_s6;
	logic [33:0]   phx_s6, phy_s6;
	logic [RW-1:0] d16_s6;
	logic          dz_s6, nx_s6, ny_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (ce) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			plx_s6 <= plx;
			ply_s6 <= ply;
			phx_s6 <= phx;
			phy_s6 <= phy;
			d16_s6 <= d16_s5;
			dz_s6  <= dz_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
		end
	end

	// ---------------- M3: floor(|s|*t2 / 65536) ----------------
	logic          v_s7;
	logic [33:0]   px_s7, py_s7;   // below 2^32 since |s| <= d16/2
	logic [RW-1:0] d16_s7;
	logic          dz_s7, nx_s7, ny_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (ce) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			px_s7  <= phx_s6 + {17'b0, plx_s6[32:16]};
			py_s7  <= phy_s6 + {17'b0, ply_s6[32:16]};
			d16_s7 <= dz_s6 ? RW'(1) : d16_s6;
			dz_s7  <= dz_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
		end
	end

	// ---------------- scaling by 1/d16, quotient at most 32768 ----------------
	logic          v_ox, v_oy;
	logic [QW-1:0] qx, qy;
	logic [1:0]    pay_ox;
	logic          pay_oy;

	sdz_div #(.DW(RW), .QW(QW), .PW(2)) u_xdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s7),
		.in_rem    (px_s7[32:16]),
		.in_low    (px_s7[15:0]),
		.in_div    (d16_s7),
		.in_pay    ({dz_s7, nx_s7}),
		.out_valid (v_ox),
		.out_quo   (qx),
		.out_pay   (pay_ox)
	);

	sdz_div #(.DW(RW), .QW(QW), .PW(1)) u_ydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s7),
		.in_rem    (py_s7[32:16]),
		.in_low    (py_s7[15:0]),
		.in_div    (d16_s7),
		.in_pay    (ny_s7),
		.out_valid (v_oy),
		.out_quo   (qy),
		.out_pay   (pay_oy)
	);

	// sign and dead-zone mask
	logic [16:0] mx, my, rx, ry;
	assign mx = pay_ox[1] ? '0 : {1'b0, qx};
	assign my = pay_ox[1] ? '0 : {1'b0, qy};
	assign rx = pay_ox[0] ? -mx : mx;
	assign ry = pay_oy    ? -my : my;

	// ---------------- output register + skid ----------------
	logic        in_fire;
	logic        out_vld_q;
	logic [33:0] out_q, skid_q;

	assign in_fire = v_ox && v_oy && ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || in_fire;
			skid_vld_q <= 1'b0;
		end else if (in_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : {ry, rx};
		end else if (in_fire) begin
			skid_q <= {ry, rx};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, out_q};

endmodule
`default_nettype wire

@@ hdl/sdz_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on nothing; payload rides alongside the radicand.
`default_nettype none
module sdz_sqrt #(
	parameter int RW = 17,
	parameter int PW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ce,
	input  wire logic              in_valid,
	input  wire logic [2*RW-1:0]   in_rad,
	input  wire logic [PW-1:0]     in_pay,
	output logic                   out_valid,
	output logic [RW-1:0]          out_root,
	output logic [PW-1:0]          out_pay
);

	logic              vld_s  [0:RW];
	logic [RW+1:0]     rem_s  [0:RW];
	logic [2*RW-1:0]   rad_s  [0:RW];
	logic [RW-1:0]     root_s [0:RW];
	logic [PW-1:0]     pay_s  [0:RW];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign rad_s[0]  = in_rad;
	assign root_s[0] = '0;
	assign pay_s[0]  = in_pay;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+3:0] shifted;
		logic [RW+3:0] trial;
		logic          ge;
		logic [RW+3:0] diff;

		assign shifted = {rem_s[i], rad_s[i][2*RW-1 -: 2]};
		assign trial   = {2'b00, root_s[i], 2'b01};
		assign ge      = shifted >= trial;
		assign diff    = shifted - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
				rad_s[i+1]  <= {rad_s[i][2*RW-3:0], 2'b00};
				root_s[i+1] <= {root_s[i][RW-2:0], ge};
				pay_s[i+1]  <= pay_s[i];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_pay   = pay_s[RW];

endmodule
`default_nettype wire

@@ hdl/sdz_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Needs in_rem < in_div; payload rides alongside.
`default_nettype none
module sdz_div #(
	parameter int DW = 17,
	parameter int QW = 16,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ce,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [QW-1:0] in_low,
	input  wire logic [DW-1:0] in_div,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [QW-1:0]      out_quo,
	output logic [PW-1:0]      out_pay
);

	logic          vld_s [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [DW-1:0] div_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [PW-1:0] pay_s [0:QW];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_rem;
	assign low_s[0] = in_low;
	assign div_s[0] = in_div;
	assign quo_s[0] = '0;
	assign pay_s[0] = in_pay;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0] shifted;
		logic [DW:0] diff;
		logic        ge;

		assign shifted = {rem_s[i], low_s[i][QW-1]};
		assign ge      = shifted >= {1'b0, div_s[i]};
		assign diff    = shifted - {1'b0, div_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ce) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				low_s[i+1] <= low_s[i] << 1;
				div_s[i+1] <= div_s[i];
				quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
				pay_s[i+1] <= pay_s[i];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_pay   = pay_s[QW];

endmodule
`default_nettype wire
